### sv/vdl_pkg.sv
package vdl_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODEL_COLOR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_COLOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COLOR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DIRECTION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERBRIGHT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_BRIGHT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FROM_LIGHT = 3'd7;

    localparam logic [31:0] RST_MODEL_COLOR   = 32'h0000_00FF;
    localparam logic [31:0] RST_SURFACE_COLOR = 32'h0000_0000;
    localparam logic [31:0] RST_AMBIENT_COLOR = 32'h0000_00FF;
    localparam logic [31:0] RST_LIGHT_COLOR   = 32'h0000_00FF;

    localparam logic [7:0]  AMB_CLAMP   = 8'd127;
    localparam logic [7:0]  FB_SCALE    = 8'd127;
    localparam logic [7:0]  BYTE_MAX    = 8'd255;
    // 1.0 in Q2.28
    localparam logic [28:0] DOT_ONE     = 29'h1000_0000;
    localparam logic [36:0] DOT_HALF    = 37'h0_0800_0000;

    typedef struct packed {
        logic [31:0] model_color;
        logic [31:0] surface_color;
        logic [31:0] ambient_color;
        logic [31:0] light_color;
        logic [47:0] light_direction;
        logic        overbright_enable;
        logic        full_bright;
        logic        alpha_from_light;
    } t_cfg;

    // exact (x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

### sv/vdl_in_if.sv
interface vdl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_vertex;

    modport source (output valid, normal_x, normal_y, normal_z, last_vertex, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, last_vertex, output ready);
endinterface

### sv/vdl_out_if.sv
interface vdl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       end_of_mesh;

    modport source (output valid, red, green, blue, alpha, end_of_mesh, input ready);
    modport sink   (input valid, red, green, blue, alpha, end_of_mesh, output ready);
endinterface

### sv/vdl_cfg_if.sv
interface vdl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [vdl_pkg::CFG_IDX_W-1:0]    index;
    logic [47:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/vdl_dot.sv
module vdl_dot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vdl_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_nx,
    input  logic signed [15:0] i_ny,
    input  logic signed [15:0] i_nz,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_diff,
    output logic               o_last
);

    logic [2:0] r_v;
    logic [2:0] en;

    logic signed [31:0] r_px, r_py, r_pz;
    logic               r_last1, r_last2, r_last3;
    logic [28:0]        r_ud;
    logic [7:0]         r_diff;

    logic signed [33:0] n_sum;
    logic [28:0]        n_ud;
    logic [36:0]        n_scaled;

    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];

    always_comb begin
        n_sum = {{2{r_px[31]}}, r_px} + {{2{r_py[31]}}, r_py} + {{2{r_pz[31]}}, r_pz};
        // clamp to 0.0 .. 1.0
        if (n_sum[33]) begin
            n_ud = '0;
        end else if (n_sum > 34'($unsigned(vdl_pkg::DOT_ONE))) begin
            n_ud = vdl_pkg::DOT_ONE;
        end else begin
            n_ud = n_sum[28:0];
        end
        // ud * 255, round half up
        n_scaled = ({8'd0, r_ud} << 8) - {8'd0, r_ud} + vdl_pkg::DOT_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_px    <= i_nx * $signed(i_cfg.light_direction[15:0]);
            r_py    <= i_ny * $signed(i_cfg.light_direction[31:16]);
            r_pz    <= i_nz * $signed(i_cfg.light_direction[47:32]);
            r_last1 <= i_last;
        end
        if (en[1]) begin
            r_ud    <= n_ud;
            r_last2 <= r_last1;
        end
        if (en[2]) begin
            r_diff  <= n_scaled[35:28];
            r_last3 <= r_last2;
        end
    end

    assign o_valid = r_v[2];
    assign o_diff  = r_diff;
    assign o_last  = r_last3;

    a_clamp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> r_ud <= vdl_pkg::DOT_ONE)
        else $error("clamped dot product above 1.0");

endmodule

### sv/vdl_shade.sv
module vdl_shade (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vdl_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_diff,
    input  logic          i_last,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic [7:0]    o_alpha,
    output logic          o_end
);

    logic [2:0] r_v;
    logic [2:0] en;

    // stage A: byte products
    logic [15:0] r_ld [3];
    logic [15:0] r_mp [4];
    logic [15:0] r_fp [3];
    logic [7:0]  r_diff_a, r_diff_b;
    logic        r_last_a, r_last_b, r_last_c;
    // stage B: modulated color and light sum
    logic [7:0]  r_mod [4];
    logic [9:0]  r_sum [3];
    logic [7:0]  r_fbq [3];
    // stage C: result
    logic [7:0]  r_rgb [3];
    logic [7:0]  r_alpha;

    logic [15:0] n_ld [3];
    logic [15:0] n_mp [4];
    logic [15:0] n_fp [3];
    logic [7:0]  n_mod [4];
    logic [9:0]  n_sum [3];
    logic [7:0]  n_fbq [3];
    logic [7:0]  n_rgb [3];
    logic [7:0]  n_alpha;

    assign en[2]   = !r_v[2] || i_ready;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];

    always_comb begin
        logic [8:0]  amb;
        logic [8:0]  lsh;
        logic [17:0] prod;
        for (int c = 0; c < 4; c++) begin
            n_mp[c]  = i_cfg.model_color[31-8*c -: 8] * i_cfg.surface_color[31-8*c -: 8];
            n_mod[c] = vdl_pkg::div255(r_mp[c]);
        end
        for (int c = 0; c < 3; c++) begin
            n_ld[c]  = i_cfg.light_color[31-8*c -: 8] * i_diff;
            n_fp[c]  = i_cfg.surface_color[31-8*c -: 8] * vdl_pkg::FB_SCALE;
            n_fbq[c] = vdl_pkg::div255(r_fp[c]);
            if (i_cfg.overbright_enable) begin
                amb = (i_cfg.ambient_color[31-8*c -: 8] > vdl_pkg::AMB_CLAMP)
                    ? {1'b0, vdl_pkg::AMB_CLAMP} : {1'b0, i_cfg.ambient_color[31-8*c -: 8]};
                lsh = {1'b0, r_ld[c][15:8]};
            end else begin
                amb = {i_cfg.ambient_color[31-8*c -: 8], 1'b0};
                lsh = r_ld[c][15:7];
            end
            n_sum[c] = {1'b0, amb} + {1'b0, lsh};
            prod     = r_mod[c] * r_sum[c];
            // full bright bypasses the product; otherwise saturate at 255
            if (i_cfg.full_bright) begin
                n_rgb[c] = i_cfg.overbright_enable ? r_fbq[c] : i_cfg.surface_color[31-8*c -: 8];
            end else if (prod[17:16] != 2'd0) begin
                n_rgb[c] = vdl_pkg::BYTE_MAX;
            end else begin
                n_rgb[c] = prod[15:8];
            end
        end
        if (i_cfg.full_bright) begin
            n_alpha = i_cfg.surface_color[7:0];
        end else if (i_cfg.alpha_from_light) begin
            n_alpha = r_diff_b;
        end else begin
            n_alpha = r_mod[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ld     <= n_ld;
            r_mp     <= n_mp;
            r_fp     <= n_fp;
            r_diff_a <= i_diff;
            r_last_a <= i_last;
        end
        if (en[1]) begin
            r_mod    <= n_mod;
            r_sum    <= n_sum;
            r_fbq    <= n_fbq;
            r_diff_b <= r_diff_a;
            r_last_b <= r_last_a;
        end
        if (en[2]) begin
            r_rgb    <= n_rgb;
            r_alpha  <= n_alpha;
            r_last_c <= r_last_b;
        end
    end

    assign o_valid = r_v[2];
    assign o_red   = r_rgb[0];
    assign o_green = r_rgb[1];
    assign o_blue  = r_rgb[2];
    assign o_alpha = r_alpha;
    assign o_end   = r_last_c;

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> r_sum[0] <= 10'd1018 && r_sum[1] <= 10'd1018 && r_sum[2] <= 10'd1018)
        else $error("ambient plus light term out of range");

endmodule

### sv/vertex_diffuse_lighting_core.sv
// Per-vertex Lambert diffuse lighting.
// i_in carries one vertex normal per beat (signed Q1.14 x, y, z and a last-vertex
// flag). o_out returns one RGBA beat per vertex, in order, with end_of_mesh copied
// from the flag. i_cfg writes the lighting registers by index (model, surface,
// ambient and light colors, light direction, overbright, full bright, alpha from
// light); it is always ready. The user must ensure it is written only while no
// vertex is in flight; the block itself does not enforce this. Six register
// stages lie between an input beat and its output beat: three form the clamped
// dot product and the diffuse byte, three more form the byte products, the
// ambient-plus-light term and the saturated channel product. Throughput is one
// vertex per cycle while o_out is not stalled; the pipeline depth is set by the
// 16x16 dot-product multipliers and the byte multiply / divide-by-255 chain. Each
// stage holds only when it is full and the stage after it holds, so a stalled
// receiver stops the pipeline without loss and bubbles still close up; i_in.ready
// drops only when all six stages are full and o_out is stalled. Reset
// (synchronous, active low) empties the pipeline and loads the register defaults.
module vertex_diffuse_lighting_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vdl_in_if.sink    i_in,
    vdl_out_if.source o_out,
    vdl_cfg_if.sink   i_cfg
);

    vdl_pkg::t_cfg r_cfg;

    logic       dot_valid;
    logic       shade_ready;
    logic [7:0] dot_diff;
    logic       dot_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.model_color       <= vdl_pkg::RST_MODEL_COLOR;
            r_cfg.surface_color     <= vdl_pkg::RST_SURFACE_COLOR;
            r_cfg.ambient_color     <= vdl_pkg::RST_AMBIENT_COLOR;
            r_cfg.light_color       <= vdl_pkg::RST_LIGHT_COLOR;
            r_cfg.light_direction   <= '0;
            r_cfg.overbright_enable <= 1'b0;
            r_cfg.full_bright       <= 1'b0;
            r_cfg.alpha_from_light  <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vdl_pkg::REG_MODEL_COLOR:      r_cfg.model_color       <= i_cfg.data[31:0];
                vdl_pkg::REG_SURFACE_COLOR:    r_cfg.surface_color     <= i_cfg.data[31:0];
                vdl_pkg::REG_AMBIENT_COLOR:    r_cfg.ambient_color     <= i_cfg.data[31:0];
                vdl_pkg::REG_LIGHT_COLOR:      r_cfg.light_color       <= i_cfg.data[31:0];
                vdl_pkg::REG_LIGHT_DIRECTION:  r_cfg.light_direction   <= i_cfg.data;
                vdl_pkg::REG_OVERBRIGHT:       r_cfg.overbright_enable <= i_cfg.data[0];
                vdl_pkg::REG_FULL_BRIGHT:      r_cfg.full_bright       <= i_cfg.data[0];
                vdl_pkg::REG_ALPHA_FROM_LIGHT: r_cfg.alpha_from_light  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    vdl_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_nx    (i_in.normal_x),
        .i_ny    (i_in.normal_y),
        .i_nz    (i_in.normal_z),
        .i_last  (i_in.last_vertex),
        .o_valid (dot_valid),
        .i_ready (shade_ready),
        .o_diff  (dot_diff),
        .o_last  (dot_last)
    );

    vdl_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (dot_valid),
        .o_ready (shade_ready),
        .i_diff  (dot_diff),
        .i_last  (dot_last),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_red   (o_out.red),
        .o_green (o_out.green),
        .o_blue  (o_out.blue),
        .o_alpha (o_out.alpha),
        .o_end   (o_out.end_of_mesh)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid && !o_out.ready)
        else $error("input held off while output side is free");

    a_bubble_into_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dot_valid && !shade_ready |-> o_out.valid && !o_out.ready)
        else $error("inner stall without output stall");

endmodule
